[rtl/core/hga_pkg.sv]
// Shared constants and types for the hash group-by aggregator.
package hga_pkg;

    localparam int TABLE_SLOTS  = 4096;
    localparam int LOAD_PERCENT = 72;
    localparam int SLOT_W       = $clog2(TABLE_SLOTS);
    localparam int USED_W       = SLOT_W + 1;
    // claiming is refused once used_slots reaches this value
    localparam int LOAD_LIMIT   = (TABLE_SLOTS * LOAD_PERCENT + 99) / 100 - 1;

    localparam logic [63:0] MIX_C0 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [30:0] SAT31     = 31'h7fffffff;
    localparam logic [14:0] ORDER_MAX = 15'h7fff;

    typedef struct packed {
        logic [30:0] cart_count;
        logic [31:0] pos_sum;
        logic [14:0] max_ord;
        logic [14:0] min_ord;
        logic [30:0] rebuy_cnt;
        logic [30:0] buy_cnt;
    } agg_t;

    localparam int AGG_W = $bits(agg_t);

    typedef struct packed {
        logic [30:0] cart_count;
        logic [31:0] pos_sum;
        logic [14:0] max_ord;
        logic [14:0] min_ord;
        logic [30:0] rebuy_cnt;
        logic [30:0] buy_cnt;
        logic [30:0] out_product;
        logic [30:0] out_customer;
        logic        entry_valid;
        logic        table_full;
        logic        new_entry;
        logic [11:0] slot;
    } res_t;

endpackage

[rtl/core/hga_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/hga_hash.sv]
// Multi-cycle splitmix64 finalizer built on one shared 32x32 multiplier.
module hga_hash
    import hga_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       key,
    output logic              done,
    output logic [SLOT_W-1:0] home
);

    logic [63:0]       v_reg, acc_reg, prod_reg;
    logic [63:0]       x, acc_next, cst, fin, mul_p;
    logic [31:0]       mul_a, mul_b;
    logic [2:0]        step_reg;
    logic              round_reg, busy_reg, done_reg;
    logic [SLOT_W-1:0] home_reg;

    assign x     = key + MIX_C0;
    assign cst   = round_reg ? MIX_C2 : MIX_C1;
    assign fin   = acc_reg ^ (acc_reg >> 31);
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a    = v_reg[31:0];
        mul_b    = cst[31:0];
        acc_next = acc_reg;
        case (step_reg)
            3'd2: begin
                mul_a    = v_reg[63:32];
                acc_next = prod_reg;
            end
            3'd3: begin
                mul_b    = cst[63:32];
                acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            end
            3'd4: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 3'd0;
            round_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg     <= x ^ (x >> 30);
                step_reg  <= 3'd1;
                round_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                prod_reg <= mul_p;
                acc_reg  <= acc_next;
                if (step_reg == 3'd5) begin
                    if (!round_reg) begin
                        v_reg     <= acc_reg ^ (acc_reg >> 27);
                        round_reg <= 1'b1;
                        step_reg  <= 3'd1;
                    end else begin
                        home_reg <= fin[SLOT_W-1:0];
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                        step_reg <= 3'd0;
                    end
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

[rtl/core/hash_group_by_aggregator.sv]
// Top level of the hash group-by aggregator: probe sequencer and stream ports.
//
// Input transfers on s_*: s_tuser is the mode (0 aggregate a purchase row,
// 1 read the slot in slot_index). Every input transfer gives exactly one
// result transfer on m_*.
// Aggregate mode hashes the (customer, product) key with splitmix64 on a
// shared 32x32 multiplier, then walks the table by linear probing: each
// probe is a registered read of the key and aggregate memories and a
// compare/update step.
// One item is in flight at a time; the next is taken as soon as the engine is
// idle, while the previous result may still wait in the output register.
// If m_tready stays low, the finished result of the following item is held
// inside and the input side stops accepting.
// After reset the key memory is swept to empty, one slot per cycle, over all
// 4096 slots; s_tready stays low during that pass.
module hash_group_by_aggregator
    import hga_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // customer[30:0], product[61:31], ord_num[76:62], cart_position[92:77],
    // reordered[93], slot_index[105:94], zero fill
    input  logic [111:0] s_tdata,
    // mode[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[11:0], new_entry[12], table_full[13], entry_valid[14],
    // out_customer[45:15], out_product[76:46], buy_cnt[107:77],
    // rebuy_cnt[138:108], min_ord[153:139], max_ord[168:154],
    // pos_sum[200:169], cart_count[231:201]
    output logic [231:0] m_tdata
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]        state_reg;
    logic [USED_W-1:0] clr_reg;
    logic [USED_W-1:0] used_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              mode_reg, reord_reg;
    logic [30:0]       cust_reg, prod_reg;
    logic [14:0]       onum_reg;
    logic [15:0]       cart_reg;
    res_t              res_reg;
    logic              m_tvalid_reg;
    logic [231:0]      m_tdata_reg;

    logic              accept, hash_start, hash_done;
    logic [SLOT_W-1:0] home;
    logic [63:0]       in_key, probe_key, raw;
    logic [63:0]       key_rdata, key_wdata;
    logic [SLOT_W-1:0] key_waddr;
    logic              key_we, agg_we;
    logic [AGG_W-1:0]  agg_rdata;
    agg_t              agg_cur, agg_base, agg_new;
    logic              is_empty, is_hit, at_limit;
    logic [32:0]       cart_add;
    res_t              res_next;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_key     = {1'b0, s_tdata[30:0], 1'b0, s_tdata[61:31]} + 64'd1;
    assign hash_start = accept && !s_tuser;
    assign probe_key  = {1'b0, cust_reg, 1'b0, prod_reg} + 64'd1;

    hga_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (in_key),
        .done    (hash_done),
        .home    (home)
    );

    assign agg_cur  = agg_t'(agg_rdata);
    assign is_empty = (key_rdata == 64'd0);
    assign is_hit   = (key_rdata == probe_key);
    assign at_limit = (used_reg >= USED_W'(LOAD_LIMIT));
    assign raw      = key_rdata - 64'd1;

    always_comb begin
        agg_base = agg_cur;
        if (is_empty) begin
            agg_base = '0;
            agg_base.min_ord = ORDER_MAX;
        end
        agg_new = agg_base;
        agg_new.buy_cnt = (agg_base.buy_cnt == SAT31) ?
            SAT31 : agg_base.buy_cnt + 31'd1;
        agg_new.rebuy_cnt = (reord_reg && agg_base.rebuy_cnt != SAT31) ?
            agg_base.rebuy_cnt + 31'd1 : agg_base.rebuy_cnt;
        agg_new.cart_count = (agg_base.cart_count == SAT31) ?
            SAT31 : agg_base.cart_count + 31'd1;
        if (onum_reg < agg_base.min_ord) begin
            agg_new.min_ord = onum_reg;
        end
        if (onum_reg > agg_base.max_ord) begin
            agg_new.max_ord = onum_reg;
        end
        cart_add = {1'b0, agg_base.pos_sum} + {17'd0, cart_reg};
        agg_new.pos_sum = cart_add[32] ? 32'hffffffff : cart_add[31:0];
    end

    always_comb begin
        res_next = '0;
        res_next.slot = 12'(slot_reg);
        if (mode_reg) begin
            if (!is_empty) begin
                res_next.entry_valid  = 1'b1;
                res_next.out_customer = raw[62:32];
                res_next.out_product  = raw[30:0];
                res_next.buy_cnt      = agg_cur.buy_cnt;
                res_next.rebuy_cnt    = agg_cur.rebuy_cnt;
                res_next.min_ord      = agg_cur.min_ord;
                res_next.max_ord      = agg_cur.max_ord;
                res_next.pos_sum      = agg_cur.pos_sum;
                res_next.cart_count   = agg_cur.cart_count;
            end
        end else if (is_empty && at_limit) begin
            res_next.table_full = 1'b1;
        end else begin
            res_next.new_entry    = is_empty;
            res_next.entry_valid  = 1'b1;
            res_next.out_customer = cust_reg;
            res_next.out_product  = prod_reg;
            res_next.buy_cnt      = agg_new.buy_cnt;
            res_next.rebuy_cnt    = agg_new.rebuy_cnt;
            res_next.min_ord      = agg_new.min_ord;
            res_next.max_ord      = agg_new.max_ord;
            res_next.pos_sum      = agg_new.pos_sum;
            res_next.cart_count   = agg_new.cart_count;
        end
    end

    // claim or update only on the compare cycle of an aggregate row
    assign agg_we = (state_reg == ST_CHK) && !mode_reg &&
                    (is_hit || (is_empty && !at_limit));
    assign key_we = (state_reg == ST_CLEAR) ||
                    ((state_reg == ST_CHK) && !mode_reg && is_empty && !at_limit);
    assign key_waddr = (state_reg == ST_CLEAR) ? clr_reg[SLOT_W-1:0] : slot_reg;
    assign key_wdata = (state_reg == ST_CLEAR) ? 64'd0 : probe_key;

    hga_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (slot_reg),
        .rdata (key_rdata)
    );

    hga_ram #(.WIDTH(AGG_W), .DEPTH(TABLE_SLOTS)) u_agg_ram (
        .aclk  (aclk),
        .we    (agg_we),
        .waddr (slot_reg),
        .wdata (AGG_W'(agg_new)),
        .raddr (slot_reg),
        .rdata (agg_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + USED_W'(1);
                    if (clr_reg == USED_W'(TABLE_SLOTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        mode_reg  <= s_tuser;
                        cust_reg  <= s_tdata[30:0];
                        prod_reg  <= s_tdata[61:31];
                        onum_reg  <= s_tdata[76:62];
                        cart_reg  <= s_tdata[92:77];
                        reord_reg <= s_tdata[93];
                        slot_reg  <= s_tdata[94 +: SLOT_W];
                        state_reg <= s_tuser ? ST_RD : ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (hash_done) begin
                        slot_reg  <= home;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: state_reg <= ST_CHK;
                ST_CHK: begin
                    if (!mode_reg && !is_empty && !is_hit) begin
                        // advance the probe, wrapping at the table end
                        slot_reg  <= slot_reg + SLOT_W'(1);
                        state_reg <= ST_RD;
                    end else begin
                        if (!mode_reg && is_empty && !at_limit) begin
                            used_reg <= used_reg + USED_W'(1);
                        end
                        res_reg   <= res_next;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= 232'(res_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/hga_checker.sv]
// Port-level assertions for the hash group-by aggregator, bound to the top.
module hga_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [231:0] m_tdata
);

    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input taken while an item is in flight");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> !m_tdata[12] && !m_tdata[14])
        else $error("refused row reports an entry");

    a_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[14] && m_tdata[107:77] == 31'd1
            && m_tdata[231:201] == 31'd1)
        else $error("fresh entry counts not one");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[14] |-> m_tdata[107:77] == 31'd0
            && m_tdata[200:169] == 32'd0)
        else $error("empty slot carries aggregates");

endmodule

bind hash_group_by_aggregator hga_checker u_hga_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
